FILE: sv/chbc_pkg.sv
`default_nettype none

package chbc_pkg;

  // Default geometry of the cache.
  localparam int BUCKETS_DEF = 256;
  localparam int POOL_DEF    = 1024;

  // Field widths fixed by the interface.
  localparam int CMD_W       = 3;
  localparam int KEY_W       = 32;
  localparam int TIME_W      = 32;
  localparam int CLIENT_W    = 6;
  localparam int PAYLOAD_W   = 64;
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 10;
  localparam int REMOVED_W   = 11;
  localparam int FRESH_W     = 16;
  localparam int EXPIRE_W    = 20;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;

  // Register reset values.
  localparam logic [FRESH_W-1:0]  FRESH_RST  = 16'd200;
  localparam logic [EXPIRE_W-1:0] EXPIRE_RST = 20'd5000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRESH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE = 2'd1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SWEEP  = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COMPUTE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NULL_KEY  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd5;

  // Memory write operations issued by the controller.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_STORE,
    WR_CREATE,
    WR_LINK,
    WR_WIPE
  } wr_op_e;

  // Result selections issued by the controller.
  typedef enum logic [2:0] {
    RS_NULL,
    RS_DONE,
    RS_FOUND,
    RS_STORED,
    RS_NOT_FOUND,
    RS_FULL,
    RS_CREATED,
    RS_REMOVED
  } res_sel_e;

  // One pool entry, without its chain link.
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic                 valid;
    logic [TIME_W-1:0]    stamp;
    logic [CLIENT_W-1:0]  client;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     cap;
    logic     wkey_ld;
    logic     wkey_src_rd;
    logic     mod_go;
    logic     head_re;
    logic     idx_ld;
    logic     walk_re;
    logic     walk_adv;
    logic     scan_clr;
    logic     scan_inc;
    logic     scan_re;
    logic     rm_ld_live;
    wr_op_e   wr_op;
    logic     res_go;
    res_sel_e res_sel;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             key_zero;
    logic             mod_done;
    logic             idx_end;
    logic             key_match;
    logic             rd_key_zero;
    logic             sweep_cand;
    logic             scan_last;
    logic             clr_last;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/chbc_ram.sv
`default_nettype none

module chbc_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/chbc_mod.sv
`default_nettype none

module chbc_mod #(
  parameter int BUCKETS = chbc_pkg::BUCKETS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [chbc_pkg::KEY_W-1:0]  key_i,
  output logic                        done_o,
  output logic [$clog2(BUCKETS)-1:0]  rem_o
);

  localparam int KEY_W = chbc_pkg::KEY_W;
  localparam int HAW   = $clog2(BUCKETS);
  localparam int RW    = HAW + 1;
  localparam int SPC   = 8;
  localparam int NCYC  = KEY_W / SPC;
  localparam int CW    = $clog2(NCYC + 1);
  localparam logic [RW-1:0] BKT = RW'(BUCKETS);

  logic [KEY_W-1:0] sh_q;
  logic [HAW-1:0]   rem_q, rem_d;
  logic [CW-1:0]    cnt_q;
  logic [RW-1:0]    trial;

  // Remainder by long division, a few key bits per cycle, most significant first.
  always_comb begin
    rem_d = rem_q;
    trial = '0;
    for (int i = 0; i < SPC; i++) begin
      trial = {rem_d, sh_q[KEY_W-1-i]};
      if (trial >= BKT) begin
        trial = trial - BKT;
      end
      rem_d = trial[HAW-1:0];
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (go_i) begin
      cnt_q <= CW'(NCYC);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Dividend shifter and partial remainder.
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      sh_q  <= key_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      sh_q  <= sh_q << SPC;
      rem_q <= rem_d;
    end
  end

  assign done_o = (cnt_q == '0);
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: sv/chbc_datapath.sv
`default_nettype none

module chbc_datapath #(
  parameter int BUCKETS      = chbc_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = chbc_pkg::POOL_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  chbc_pkg::ctrl_t                     ctrl_i,
  output chbc_pkg::stat_t                     stat_o,
  input  logic                                cfg_we_i,
  input  logic [chbc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [chbc_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic [chbc_pkg::CMD_W-1:0]          command_i,
  input  logic [chbc_pkg::KEY_W-1:0]          key_i,
  input  logic signed [chbc_pkg::TIME_W-1:0]  now_time_i,
  input  logic [chbc_pkg::CLIENT_W-1:0]       client_id_i,
  input  logic                                force_recalc_i,
  input  logic [chbc_pkg::PAYLOAD_W-1:0]      payload_in_i,
  output logic                                done_o,
  output logic [chbc_pkg::STATUS_W-1:0]       status_o,
  output logic [chbc_pkg::PAYLOAD_W-1:0]      payload_out_o,
  output logic [chbc_pkg::SLOT_W-1:0]         slot_o,
  output logic [chbc_pkg::REMOVED_W-1:0]      removed_count_o
);

  localparam int PAW       = $clog2(POOL_ENTRIES);
  localparam int LW        = PAW + 1;
  localparam int HAW       = $clog2(BUCKETS);
  localparam int MAXD      = (POOL_ENTRIES > BUCKETS) ? POOL_ENTRIES : BUCKETS;
  localparam int SW        = $clog2(MAXD) + 1;
  localparam int DT_W      = chbc_pkg::TIME_W + 2;
  localparam int SLOT_W    = chbc_pkg::SLOT_W;
  localparam int REMOVED_W = chbc_pkg::REMOVED_W;
  localparam int ENTRY_W   = $bits(chbc_pkg::entry_t);
  localparam logic [LW-1:0] LINK_END = {LW{1'b1}};

  // Captured command.
  logic [chbc_pkg::CMD_W-1:0]     cmd_q;
  logic [chbc_pkg::KEY_W-1:0]     key_q;
  logic [chbc_pkg::TIME_W-1:0]    now_q;
  logic [chbc_pkg::CLIENT_W-1:0]  client_q;
  logic                           force_q;
  logic [chbc_pkg::PAYLOAD_W-1:0] payload_q;

  // Configuration.
  logic [chbc_pkg::FRESH_W-1:0]   fresh_q;
  logic [chbc_pkg::EXPIRE_W-1:0]  expire_q;

  // Walk and scan state.
  logic [chbc_pkg::KEY_W-1:0]     wkey_q;
  logic [LW-1:0]                  idx_q, prev_q, headv_q;
  logic [SW-1:0]                  scan_q;
  logic [LW-1:0]                  live_q, removed_q;

  // Result registers.
  logic                           done_q;
  logic [chbc_pkg::STATUS_W-1:0]  status_q;
  logic [chbc_pkg::PAYLOAD_W-1:0] pout_q;
  logic [PAW-1:0]                 slot_q;
  logic [LW-1:0]                  rmv_q;

  // Memory ports.
  chbc_pkg::entry_t  fld_rd, fld_wdata;
  logic [ENTRY_W-1:0] fld_rd_raw;
  logic              fld_we, fld_re;
  logic [PAW-1:0]    fld_waddr, fld_raddr;
  logic [LW-1:0]     nxt_rd, nxt_wdata, hd_rd, hd_wdata;
  logic              nxt_we, hd_we;
  logic [PAW-1:0]    nxt_waddr;
  logic [HAW-1:0]    hd_waddr;

  // Bucket unit.
  logic                        mod_done;
  logic [HAW-1:0]              bucket;
  logic [chbc_pkg::KEY_W-1:0]  mod_key;

  // Decoded helpers.
  logic [PAW-1:0] idx_addr, prev_addr, scan_paddr;
  logic [HAW-1:0] scan_haddr;
  logic [LW-1:0]  scan_link;
  logic           scan_in_pool, scan_in_bkt, prev_end;
  logic [DT_W-1:0] fresh_diff, expire_diff;
  logic           hit, expired;

  // Result selection.
  logic [chbc_pkg::STATUS_W-1:0]  res_status;
  logic [chbc_pkg::PAYLOAD_W-1:0] res_pay;
  logic [PAW-1:0]                 res_slot;
  logic [LW-1:0]                  res_rm;

  assign fld_rd       = chbc_pkg::entry_t'(fld_rd_raw);
  assign idx_addr     = idx_q[PAW-1:0];
  assign prev_addr    = prev_q[PAW-1:0];
  assign scan_paddr   = scan_q[PAW-1:0];
  assign scan_haddr   = scan_q[HAW-1:0];
  assign scan_link    = {1'b0, scan_paddr};
  assign scan_in_pool = (32'(scan_q) < POOL_ENTRIES);
  assign scan_in_bkt  = (32'(scan_q) < BUCKETS);
  assign prev_end     = (32'(prev_q) >= POOL_ENTRIES);

  // Age tests on exact widened time differences.
  assign fresh_diff  = DT_W'($signed(fld_rd.stamp)) - DT_W'($signed(now_q)) + DT_W'(fresh_q);
  assign expire_diff = DT_W'($signed(now_q)) - DT_W'($signed(fld_rd.stamp)) - DT_W'(expire_q);
  assign hit     = fld_rd.valid && !force_q && !fresh_diff[DT_W-1] && (fld_rd.client == client_q);
  assign expired = !expire_diff[DT_W-1] && (expire_diff != '0);

  // Bucket index of the key being walked.
  assign mod_key = ctrl_i.wkey_src_rd ? fld_rd.key : key_q;

  chbc_mod #(
    .BUCKETS (BUCKETS)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (ctrl_i.mod_go),
    .key_i  (mod_key),
    .done_o (mod_done),
    .rem_o  (bucket)
  );

  // Read side of the memories.
  assign fld_re    = ctrl_i.walk_re | ctrl_i.scan_re;
  assign fld_raddr = ctrl_i.scan_re ? scan_paddr : idx_addr;

  // Write side of the memories.
  always_comb begin
    fld_we    = 1'b0;
    fld_waddr = idx_addr;
    fld_wdata = '0;
    nxt_we    = 1'b0;
    nxt_waddr = idx_addr;
    nxt_wdata = LINK_END;
    hd_we     = 1'b0;
    hd_waddr  = bucket;
    hd_wdata  = LINK_END;
    case (ctrl_i.wr_op)
      chbc_pkg::WR_CLEAR: begin
        fld_we    = scan_in_pool;
        fld_waddr = scan_paddr;
        nxt_we    = scan_in_pool;
        nxt_waddr = scan_paddr;
        hd_we     = scan_in_bkt;
        hd_waddr  = scan_haddr;
      end
      chbc_pkg::WR_STORE: begin
        fld_we            = 1'b1;
        fld_wdata.key     = fld_rd.key;
        fld_wdata.valid   = 1'b1;
        fld_wdata.stamp   = now_q;
        fld_wdata.client  = client_q;
        fld_wdata.payload = payload_q;
      end
      chbc_pkg::WR_CREATE: begin
        fld_we        = 1'b1;
        fld_waddr     = scan_paddr;
        fld_wdata.key = key_q;
        nxt_we        = 1'b1;
        nxt_waddr     = scan_paddr;
        nxt_wdata     = headv_q;
        hd_we         = 1'b1;
        hd_wdata      = scan_link;
      end
      chbc_pkg::WR_LINK: begin
        if (prev_end) begin
          hd_we    = 1'b1;
          hd_wdata = nxt_rd;
        end else begin
          nxt_we    = 1'b1;
          nxt_waddr = prev_addr;
          nxt_wdata = nxt_rd;
        end
      end
      chbc_pkg::WR_WIPE: begin
        fld_we = 1'b1;
        nxt_we = 1'b1;
      end
      default: ;
    endcase
  end

  chbc_ram #(
    .DW    (ENTRY_W),
    .DEPTH (POOL_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (fld_we),
    .waddr_i (fld_waddr),
    .wdata_i (fld_wdata),
    .re_i    (fld_re),
    .raddr_i (fld_raddr),
    .rdata_o (fld_rd_raw)
  );

  chbc_ram #(
    .DW    (LW),
    .DEPTH (POOL_ENTRIES)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (ctrl_i.walk_re),
    .raddr_i (idx_addr),
    .rdata_o (nxt_rd)
  );

  chbc_ram #(
    .DW    (LW),
    .DEPTH (BUCKETS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (hd_we),
    .waddr_i (hd_waddr),
    .wdata_i (hd_wdata),
    .re_i    (ctrl_i.head_re),
    .raddr_i (bucket),
    .rdata_o (hd_rd)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q  <= chbc_pkg::FRESH_RST;
      expire_q <= chbc_pkg::EXPIRE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        chbc_pkg::CFG_FRESH:  fresh_q  <= cfg_wdata_i[chbc_pkg::FRESH_W-1:0];
        chbc_pkg::CFG_EXPIRE: expire_q <= cfg_wdata_i[chbc_pkg::EXPIRE_W-1:0];
        default: ;
      endcase
    end
  end

  // Command capture and chain walk registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      cmd_q     <= command_i;
      key_q     <= key_i;
      now_q     <= $unsigned(now_time_i);
      client_q  <= client_id_i;
      force_q   <= force_recalc_i;
      payload_q <= payload_in_i;
    end
    if (ctrl_i.wkey_ld) begin
      wkey_q <= mod_key;
    end
    if (ctrl_i.idx_ld) begin
      idx_q   <= hd_rd;
      headv_q <= hd_rd;
      prev_q  <= LINK_END;
    end else if (ctrl_i.walk_adv) begin
      prev_q <= idx_q;
      idx_q  <= nxt_rd;
    end
  end

  // Scan counter and entry counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      live_q    <= '0;
      removed_q <= '0;
    end else begin
      if (ctrl_i.scan_clr) begin
        scan_q <= '0;
      end else if (ctrl_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (ctrl_i.cap) begin
        removed_q <= '0;
      end else if (ctrl_i.rm_ld_live) begin
        removed_q <= live_q;
      end else if (ctrl_i.wr_op == chbc_pkg::WR_WIPE) begin
        removed_q <= removed_q + 1'b1;
      end
      if (ctrl_i.rm_ld_live) begin
        live_q <= '0;
      end else if (ctrl_i.wr_op == chbc_pkg::WR_CREATE) begin
        live_q <= live_q + 1'b1;
      end else if (ctrl_i.wr_op == chbc_pkg::WR_WIPE && live_q != '0) begin
        live_q <= live_q - 1'b1;
      end
    end
  end

  // Result field selection.
  always_comb begin
    res_status = chbc_pkg::ST_DONE;
    res_pay    = '0;
    res_slot   = '0;
    res_rm     = '0;
    case (ctrl_i.res_sel)
      chbc_pkg::RS_NULL: res_status = chbc_pkg::ST_NULL_KEY;
      chbc_pkg::RS_DONE: res_rm = removed_q;
      chbc_pkg::RS_FOUND: begin
        res_slot = idx_addr;
        if ((cmd_q == chbc_pkg::CMD_LOOKUP) ? hit : fld_rd.valid) begin
          res_status = chbc_pkg::ST_HIT;
          res_pay    = fld_rd.payload;
        end else begin
          res_status = chbc_pkg::ST_COMPUTE;
        end
      end
      chbc_pkg::RS_STORED:    res_slot = idx_addr;
      chbc_pkg::RS_NOT_FOUND: res_status = chbc_pkg::ST_NOT_FOUND;
      chbc_pkg::RS_FULL:      res_status = chbc_pkg::ST_FULL;
      chbc_pkg::RS_CREATED: begin
        res_status = chbc_pkg::ST_COMPUTE;
        res_slot   = scan_paddr;
      end
      chbc_pkg::RS_REMOVED: begin
        res_slot = idx_addr;
        res_rm   = LW'(1);
      end
      default: ;
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.res_go;
    end
  end

  // Result fields.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_go) begin
      status_q <= res_status;
      pout_q   <= res_pay;
      slot_q   <= res_slot;
      rmv_q    <= res_rm;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign payload_out_o   = pout_q;
  assign slot_o          = SLOT_W'(slot_q);
  assign removed_count_o = REMOVED_W'(rmv_q);

  // Status towards the controller.
  assign stat_o.cmd         = cmd_q;
  assign stat_o.key_zero    = (key_q == '0);
  assign stat_o.mod_done    = mod_done;
  assign stat_o.idx_end     = (32'(idx_q) >= POOL_ENTRIES);
  assign stat_o.key_match   = (fld_rd.key == wkey_q);
  assign stat_o.rd_key_zero = (fld_rd.key == '0);
  assign stat_o.sweep_cand  = (fld_rd.key != '0) && fld_rd.valid && expired;
  assign stat_o.scan_last   = (scan_q == SW'(POOL_ENTRIES - 1));
  assign stat_o.clr_last    = (scan_q == SW'(MAXD - 1));

endmodule

`default_nettype wire

FILE: sv/chbc_ctrl.sv
`default_nettype none

module chbc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  chbc_pkg::stat_t stat_i,
  output chbc_pkg::ctrl_t ctrl_o
);

  typedef enum logic [14:0] {
    S_INIT = 15'b000000000000001,
    S_IDLE = 15'b000000000000010,
    S_DISP = 15'b000000000000100,
    S_MOD  = 15'b000000000001000,
    S_HEAD = 15'b000000000010000,
    S_WRD  = 15'b000000000100000,
    S_WCK  = 15'b000000001000000,
    S_LINK = 15'b000000010000000,
    S_WIPE = 15'b000000100000000,
    S_SWRD = 15'b000001000000000,
    S_SWCK = 15'b000010000000000,
    S_SWNX = 15'b000100000000000,
    S_FSRD = 15'b001000000000000,
    S_FSCK = 15'b010000000000000,
    S_CLR  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // Sequencer: issues at most one memory step per state.
  always_comb begin
    state_d        = state_q;
    ctrl_o         = '0;
    ctrl_o.wr_op   = chbc_pkg::WR_NONE;
    ctrl_o.res_sel = chbc_pkg::RS_NULL;
    unique case (state_q)
      S_INIT: begin
        ctrl_o.wr_op    = chbc_pkg::WR_CLEAR;
        ctrl_o.scan_inc = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctrl_o.cap = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.cmd <= chbc_pkg::CMD_REMOVE && stat_i.key_zero) begin
          ctrl_o.res_go  = 1'b1;
          ctrl_o.res_sel = chbc_pkg::RS_NULL;
          state_d        = S_IDLE;
        end else begin
          unique case (stat_i.cmd) inside
            chbc_pkg::CMD_CLEAR: begin
              ctrl_o.rm_ld_live = 1'b1;
              ctrl_o.scan_clr   = 1'b1;
              state_d           = S_CLR;
            end
            chbc_pkg::CMD_SWEEP: begin
              ctrl_o.scan_clr = 1'b1;
              state_d         = S_SWRD;
            end
            chbc_pkg::CMD_LOOKUP, chbc_pkg::CMD_STORE,
            chbc_pkg::CMD_QUERY, chbc_pkg::CMD_REMOVE: begin
              ctrl_o.wkey_ld = 1'b1;
              ctrl_o.mod_go  = 1'b1;
              state_d        = S_MOD;
            end
            default: begin
              ctrl_o.res_go  = 1'b1;
              ctrl_o.res_sel = chbc_pkg::RS_DONE;
              state_d        = S_IDLE;
            end
          endcase
        end
      end
      S_MOD: begin
        if (stat_i.mod_done) begin
          ctrl_o.head_re = 1'b1;
          state_d        = S_HEAD;
        end
      end
      S_HEAD: begin
        ctrl_o.idx_ld = 1'b1;
        state_d       = S_WRD;
      end
      S_WRD: begin
        if (stat_i.idx_end) begin
          if (stat_i.cmd == chbc_pkg::CMD_LOOKUP) begin
            ctrl_o.scan_clr = 1'b1;
            state_d         = S_FSRD;
          end else if (stat_i.cmd == chbc_pkg::CMD_SWEEP) begin
            state_d = S_SWNX;
          end else begin
            ctrl_o.res_go  = 1'b1;
            ctrl_o.res_sel = chbc_pkg::RS_NOT_FOUND;
            state_d        = S_IDLE;
          end
        end else begin
          ctrl_o.walk_re = 1'b1;
          state_d        = S_WCK;
        end
      end
      S_WCK: begin
        if (stat_i.key_match) begin
          if (stat_i.cmd == chbc_pkg::CMD_LOOKUP || stat_i.cmd == chbc_pkg::CMD_QUERY) begin
            ctrl_o.res_go  = 1'b1;
            ctrl_o.res_sel = chbc_pkg::RS_FOUND;
            state_d        = S_IDLE;
          end else if (stat_i.cmd == chbc_pkg::CMD_STORE) begin
            ctrl_o.wr_op   = chbc_pkg::WR_STORE;
            ctrl_o.res_go  = 1'b1;
            ctrl_o.res_sel = chbc_pkg::RS_STORED;
            state_d        = S_IDLE;
          end else begin
            state_d = S_LINK;
          end
        end else begin
          ctrl_o.walk_adv = 1'b1;
          state_d         = S_WRD;
        end
      end
      S_LINK: begin
        ctrl_o.wr_op = chbc_pkg::WR_LINK;
        state_d      = S_WIPE;
      end
      S_WIPE: begin
        ctrl_o.wr_op = chbc_pkg::WR_WIPE;
        if (stat_i.cmd == chbc_pkg::CMD_REMOVE) begin
          ctrl_o.res_go  = 1'b1;
          ctrl_o.res_sel = chbc_pkg::RS_REMOVED;
          state_d        = S_IDLE;
        end else begin
          state_d = S_SWNX;
        end
      end
      S_SWRD: begin
        ctrl_o.scan_re = 1'b1;
        state_d        = S_SWCK;
      end
      S_SWCK: begin
        if (stat_i.sweep_cand) begin
          ctrl_o.wkey_ld     = 1'b1;
          ctrl_o.wkey_src_rd = 1'b1;
          ctrl_o.mod_go      = 1'b1;
          state_d            = S_MOD;
        end else begin
          state_d = S_SWNX;
        end
      end
      S_SWNX: begin
        if (stat_i.scan_last) begin
          ctrl_o.res_go  = 1'b1;
          ctrl_o.res_sel = chbc_pkg::RS_DONE;
          state_d        = S_IDLE;
        end else begin
          ctrl_o.scan_inc = 1'b1;
          state_d         = S_SWRD;
        end
      end
      S_FSRD: begin
        ctrl_o.scan_re = 1'b1;
        state_d        = S_FSCK;
      end
      S_FSCK: begin
        if (stat_i.rd_key_zero) begin
          ctrl_o.wr_op   = chbc_pkg::WR_CREATE;
          ctrl_o.res_go  = 1'b1;
          ctrl_o.res_sel = chbc_pkg::RS_CREATED;
          state_d        = S_IDLE;
        end else if (stat_i.scan_last) begin
          ctrl_o.res_go  = 1'b1;
          ctrl_o.res_sel = chbc_pkg::RS_FULL;
          state_d        = S_IDLE;
        end else begin
          ctrl_o.scan_inc = 1'b1;
          state_d         = S_FSRD;
        end
      end
      S_CLR: begin
        ctrl_o.wr_op    = chbc_pkg::WR_CLEAR;
        ctrl_o.scan_inc = 1'b1;
        if (stat_i.clr_last) begin
          ctrl_o.res_go  = 1'b1;
          ctrl_o.res_sel = chbc_pkg::RS_DONE;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/chained_hash_bounds_cache_core.sv
`default_nettype none

// Keyed cache of packed bounds: a pool of entries linked into bucket chains.
// A command transaction is accepted on a clock edge with start high and busy
// low; the command and its operand ports are sampled at that edge. The block
// then runs alone on that command and returns exactly one result transaction:
// done_o is high for one cycle with status_o, payload_out_o, slot_o and
// removed_count_o valid. The receiver cannot stall; the result is only shown
// for that cycle. Busy drops in the cycle done_o rises, so a new command may
// be issued there.
// A lookup, store, query or remove first runs the bucket remainder unit, then
// walks the chain; each chain hop is one registered read of the entry memory.
// A lookup that creates an entry first scans the pool slots for a free one.
// Clear rewrites every memory row, one memory row per cycle; a sweep reads each
// pool slot in turn and runs a chain walk for each entry removed. After reset a
// clearing pass over every memory row runs with busy high; configuration writes
// are taken at any time.
module chained_hash_bounds_cache_core #(
  parameter int BUCKETS      = chbc_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = chbc_pkg::POOL_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [chbc_pkg::CMD_W-1:0]          command_i,
  input  logic [chbc_pkg::KEY_W-1:0]          key_i,
  input  logic signed [chbc_pkg::TIME_W-1:0]  now_time_i,
  input  logic [chbc_pkg::CLIENT_W-1:0]       client_id_i,
  input  logic                                force_recalc_i,
  input  logic [chbc_pkg::PAYLOAD_W-1:0]      payload_in_i,
  input  logic                                cfg_we_i,
  input  logic [chbc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [chbc_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic                                done_o,
  output logic [chbc_pkg::STATUS_W-1:0]       status_o,
  output logic [chbc_pkg::PAYLOAD_W-1:0]      payload_out_o,
  output logic [chbc_pkg::SLOT_W-1:0]         slot_o,
  output logic [chbc_pkg::REMOVED_W-1:0]      removed_count_o
);

  chbc_pkg::ctrl_t ctrl;
  chbc_pkg::stat_t stat;

  // Sequencer.
  chbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Memories, counters and result registers.
  chbc_datapath #(
    .BUCKETS      (BUCKETS),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (command_i),
    .key_i           (key_i),
    .now_time_i      (now_time_i),
    .client_id_i     (client_id_i),
    .force_recalc_i  (force_recalc_i),
    .payload_in_i    (payload_in_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .payload_out_o   (payload_out_o),
    .slot_o          (slot_o),
    .removed_count_o (removed_count_o)
  );

`ifndef SYNTH
  // A result only follows a cycle of work.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result strobe without a command in progress");

  // An accepted transaction makes the block busy and gives no result at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted command did not start work");

  // Memory writes only happen while the sequencer is active.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.wr_op != chbc_pkg::WR_NONE) |-> busy)
    else $error("memory write while idle");

  // The result strobe always drops again after it has been raised.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

FILE: test/chained_hash_bounds_cache_core_tb.sv
`timescale 1ns / 1ps

module chained_hash_bounds_cache_core_tb;

  localparam int NBUCK = chbc_pkg::BUCKETS_DEF;
  localparam int NPOOL = chbc_pkg::POOL_DEF;
  localparam int LINK_END = 'hFFFF;

  typedef struct {
    logic [chbc_pkg::STATUS_W-1:0]  status;
    logic [chbc_pkg::PAYLOAD_W-1:0] payload;
    logic [chbc_pkg::SLOT_W-1:0]    slot;
    logic [chbc_pkg::REMOVED_W-1:0] removed;
  } cache_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [chbc_pkg::CMD_W-1:0] command_i = '0;
  logic [chbc_pkg::KEY_W-1:0] key_i = '0;
  logic signed [chbc_pkg::TIME_W-1:0] now_time_i = '0;
  logic [chbc_pkg::CLIENT_W-1:0] client_id_i = '0;
  logic force_recalc_i = 1'b0;
  logic [chbc_pkg::PAYLOAD_W-1:0] payload_in_i = '0;
  logic cfg_we_i = 1'b0;
  logic [chbc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [chbc_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic done_o;
  logic [chbc_pkg::STATUS_W-1:0] status_o;
  logic [chbc_pkg::PAYLOAD_W-1:0] payload_out_o;
  logic [chbc_pkg::SLOT_W-1:0] slot_o;
  logic [chbc_pkg::REMOVED_W-1:0] removed_count_o;

  chained_hash_bounds_cache_core u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the cache contents and registers.
  logic [chbc_pkg::KEY_W-1:0]     sh_key[NPOOL];
  int                             sh_next[NPOOL];
  int                             sh_head[NBUCK];
  logic                           sh_valid[NPOOL];
  logic [chbc_pkg::TIME_W-1:0]    sh_time[NPOOL];
  logic [chbc_pkg::CLIENT_W-1:0]  sh_client[NPOOL];
  logic [chbc_pkg::PAYLOAD_W-1:0] sh_payload[NPOOL];
  int                             sh_live;
  longint                         sh_fresh;
  longint                         sh_expire;

  cache_result_t pending_results[$];
  int error_count = 0;
  int send_idle_pct = 0;
  longint clock_ms = 0;
  logic [chbc_pkg::KEY_W-1:0] key_set[48];

  task automatic wipe_slot(input int s);
    sh_key[s] = '0;
    sh_next[s] = LINK_END;
    sh_valid[s] = 1'b0;
    sh_time[s] = '0;
    sh_client[s] = '0;
    sh_payload[s] = '0;
  endtask

  task automatic wipe_cache();
    for (int i = 0; i < NPOOL; i++) wipe_slot(i);
    for (int i = 0; i < NBUCK; i++) sh_head[i] = LINK_END;
    sh_live = 0;
  endtask

  // Walks the bucket chain of a key; returns NPOOL when the key is absent.
  task automatic find_entry(input logic [chbc_pkg::KEY_W-1:0] k, output int found,
                            output int prev);
    int idx;
    int steps;
    idx = sh_head[k % NBUCK];
    prev = LINK_END;
    steps = 0;
    found = NPOOL;
    while (idx < NPOOL && steps < NPOOL) begin
      if (sh_key[idx] == k) begin
        found = idx;
        return;
      end
      prev = idx;
      idx = sh_next[idx];
      steps++;
    end
  endtask

  task automatic unlink_entry(input int s);
    int found;
    int prev;
    find_entry(sh_key[s], found, prev);
    if (found != s) return;
    if (prev < NPOOL) sh_next[prev] = sh_next[s];
    else sh_head[sh_key[s] % NBUCK] = sh_next[s];
    wipe_slot(s);
    if (sh_live > 0) sh_live--;
  endtask

  // Applies one command to the shadow cache and returns the expected result.
  task automatic predict_cache(input logic [chbc_pkg::CMD_W-1:0] cmd,
                               input logic [chbc_pkg::KEY_W-1:0] k,
                               input logic signed [chbc_pkg::TIME_W-1:0] now_t,
                               input logic [chbc_pkg::CLIENT_W-1:0] client, input logic frc,
                               input logic [chbc_pkg::PAYLOAD_W-1:0] pay,
                               output cache_result_t r);
    int s;
    int prev;
    int i;
    longint now_l;
    now_l = now_t;
    r.status = chbc_pkg::ST_DONE;
    r.payload = '0;
    r.slot = '0;
    r.removed = '0;
    if (cmd <= chbc_pkg::CMD_REMOVE && k == '0) begin
      r.status = chbc_pkg::ST_NULL_KEY;
      return;
    end
    case (cmd)
      chbc_pkg::CMD_LOOKUP: begin
        find_entry(k, s, prev);
        if (s < NPOOL) begin
          r.slot = chbc_pkg::SLOT_W'(s);
          if (sh_valid[s] && !frc && sh_client[s] == client &&
              longint'(signed'(sh_time[s])) >= now_l - sh_fresh) begin
            r.status = chbc_pkg::ST_HIT;
            r.payload = sh_payload[s];
          end else begin
            r.status = chbc_pkg::ST_COMPUTE;
          end
        end else begin
          for (i = 0; i < NPOOL; i++) if (sh_key[i] == '0) break;
          if (i >= NPOOL) begin
            r.status = chbc_pkg::ST_FULL;
          end else begin
            wipe_slot(i);
            sh_key[i] = k;
            sh_next[i] = sh_head[k % NBUCK];
            sh_head[k % NBUCK] = i;
            sh_live++;
            r.status = chbc_pkg::ST_COMPUTE;
            r.slot = chbc_pkg::SLOT_W'(i);
          end
        end
      end
      chbc_pkg::CMD_STORE: begin
        find_entry(k, s, prev);
        if (s < NPOOL) begin
          sh_valid[s] = 1'b1;
          sh_time[s] = now_t;
          sh_client[s] = client;
          sh_payload[s] = pay;
          r.slot = chbc_pkg::SLOT_W'(s);
        end else begin
          r.status = chbc_pkg::ST_NOT_FOUND;
        end
      end
      chbc_pkg::CMD_QUERY: begin
        find_entry(k, s, prev);
        if (s < NPOOL) begin
          r.slot = chbc_pkg::SLOT_W'(s);
          if (sh_valid[s]) begin
            r.status = chbc_pkg::ST_HIT;
            r.payload = sh_payload[s];
          end else begin
            r.status = chbc_pkg::ST_COMPUTE;
          end
        end else begin
          r.status = chbc_pkg::ST_NOT_FOUND;
        end
      end
      chbc_pkg::CMD_REMOVE: begin
        find_entry(k, s, prev);
        if (s < NPOOL) begin
          unlink_entry(s);
          r.slot = chbc_pkg::SLOT_W'(s);
          r.removed = chbc_pkg::REMOVED_W'(1);
        end else begin
          r.status = chbc_pkg::ST_NOT_FOUND;
        end
      end
      chbc_pkg::CMD_CLEAR: begin
        r.removed = chbc_pkg::REMOVED_W'(sh_live);
        wipe_cache();
      end
      chbc_pkg::CMD_SWEEP: begin
        for (i = 0; i < NPOOL; i++) begin
          if (sh_key[i] != '0 && sh_valid[i] &&
              now_l - longint'(signed'(sh_time[i])) > sh_expire) begin
            unlink_entry(i);
            r.removed++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Issues one command transaction and records its expected result.
  task automatic send_command(input logic [chbc_pkg::CMD_W-1:0] cmd,
                              input logic [chbc_pkg::KEY_W-1:0] k,
                              input logic signed [chbc_pkg::TIME_W-1:0] now_t,
                              input logic [chbc_pkg::CLIENT_W-1:0] client, input logic frc,
                              input logic [chbc_pkg::PAYLOAD_W-1:0] pay);
    cache_result_t r;
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    start <= 1'b1;
    command_i <= cmd;
    key_i <= k;
    now_time_i <= now_t;
    client_id_i <= client;
    force_recalc_i <= frc;
    payload_in_i <= pay;
    do @(posedge clk_i); while (busy);
    start <= 1'b0;
    predict_cache(cmd, k, now_t, client, frc, pay, r);
    pending_results.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_config(input logic [chbc_pkg::CFG_IDX_W-1:0] idx,
                              input logic [chbc_pkg::CFG_W-1:0] val);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == chbc_pkg::CFG_FRESH) sh_fresh = val[chbc_pkg::FRESH_W-1:0];
    else if (idx == chbc_pkg::CFG_EXPIRE) sh_expire = val[chbc_pkg::EXPIRE_W-1:0];
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: %s mismatch at %0t: got %0h, expected %0h", field, $realtime, got, want);
    error_count++;
  endtask

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    cache_result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(status_o), 64'd0);
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status)
          report_mismatch("status", 64'(status_o), 64'(e.status));
        if (payload_out_o !== e.payload)
          report_mismatch("payload", payload_out_o, e.payload);
        if (slot_o !== e.slot)
          report_mismatch("slot", 64'(slot_o), 64'(e.slot));
        if (removed_count_o !== e.removed)
          report_mismatch("removed_count", 64'(removed_count_o), 64'(e.removed));
      end
    end
  end

  task automatic test_directed();
    // Null keys on every keyed command.
    for (int c = chbc_pkg::CMD_LOOKUP; c <= chbc_pkg::CMD_REMOVE; c++)
      send_command(chbc_pkg::CMD_W'(c), '0, 0, 6'd0, 1'b0, '1);
    send_command(chbc_pkg::CMD_QUERY, 32'd5, 0, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_STORE, 32'd5, 0, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd5, 1000, 6'd3, 1'b0, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd5, 1000, 6'd3, 1'b0, '0);
    send_command(chbc_pkg::CMD_STORE, 32'd5, 1000, 6'd3, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd5, 1200, 6'd3, 1'b0, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd5, 1201, 6'd3, 1'b0, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd5, 1000, 6'd3, 1'b1, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd5, 1000, 6'd63, 1'b0, '0);
    send_command(chbc_pkg::CMD_QUERY, 32'd5, 0, 6'd0, 1'b0, '0);
    // Three keys sharing one bucket; the middle of the chain is removed.
    send_command(chbc_pkg::CMD_LOOKUP, 32'd5 + NBUCK, 0, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd5 + 2 * NBUCK, 0, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_REMOVE, 32'd5 + NBUCK, 0, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_REMOVE, 32'd5 + NBUCK, 0, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_QUERY, 32'd5 + 2 * NBUCK, 0, 6'd0, 1'b0, '0);
    // Extreme key and times.
    send_command(chbc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h8000_0000, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_STORE, 32'hFFFF_FFFF, 32'h8000_0000, 6'd63, 1'b0,
                 64'h8000_0000_0000_0001);
    send_command(chbc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 6'd63, 1'b0, '0);
    send_command(chbc_pkg::CMD_SWEEP, '0, 32'h7FFF_FFFF, 6'd0, 1'b0, '0);
    send_command(3'd6, 32'd9, 1, 6'd1, 1'b1, '1);
    send_command(3'd7, 32'd9, 1, 6'd1, 1'b1, '1);
    send_command(chbc_pkg::CMD_CLEAR, '0, 0, 6'd0, 1'b0, '0);
  endtask

  task automatic test_config_extremes();
    write_config(chbc_pkg::CFG_FRESH, '0);
    write_config(chbc_pkg::CFG_EXPIRE, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd77, 0, 6'd1, 1'b0, '0);
    send_command(chbc_pkg::CMD_STORE, 32'd77, 500, 6'd1, 1'b0, 64'h1234);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd77, 500, 6'd1, 1'b0, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd77, 501, 6'd1, 1'b0, '0);
    send_command(chbc_pkg::CMD_SWEEP, '0, 500, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_SWEEP, '0, 501, 6'd0, 1'b0, '0);
    write_config(chbc_pkg::CFG_FRESH, 20'h0FFFF);
    write_config(chbc_pkg::CFG_EXPIRE, 20'hFFFFF);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd78, 0, 6'd2, 1'b0, '0);
    send_command(chbc_pkg::CMD_STORE, 32'd78, 0, 6'd2, 1'b0, 64'h55);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd78, 65535, 6'd2, 1'b0, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd78, 65536, 6'd2, 1'b0, '0);
    send_command(chbc_pkg::CMD_SWEEP, '0, 1048575, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_SWEEP, '0, 1048576, 6'd0, 1'b0, '0);
    write_config(chbc_pkg::CFG_FRESH, chbc_pkg::CFG_W'(chbc_pkg::FRESH_RST));
    write_config(chbc_pkg::CFG_EXPIRE, chbc_pkg::CFG_W'(chbc_pkg::EXPIRE_RST));
  endtask

  // Fills the whole pool, then asks for one more entry.
  task automatic test_pool_full();
    for (int i = 1; i <= NPOOL; i++)
      send_command(chbc_pkg::CMD_LOOKUP, i, 0, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'hABCD_0001, 0, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_LOOKUP, 32'd1, 0, 6'd0, 1'b0, '0);
    send_command(chbc_pkg::CMD_CLEAR, '0, 0, 6'd0, 1'b0, '0);
  endtask

  task automatic random_item();
    logic [chbc_pkg::CMD_W-1:0] cmd;
    logic [chbc_pkg::KEY_W-1:0] k;
    logic signed [chbc_pkg::TIME_W-1:0] t;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) cmd = chbc_pkg::CMD_LOOKUP;
    else if (pick < 62) cmd = chbc_pkg::CMD_STORE;
    else if (pick < 78) cmd = chbc_pkg::CMD_QUERY;
    else if (pick < 92) cmd = chbc_pkg::CMD_REMOVE;
    else if (pick < 95) cmd = chbc_pkg::CMD_SWEEP;
    else if (pick < 96) cmd = chbc_pkg::CMD_CLEAR;
    else if (pick < 98) cmd = chbc_pkg::CMD_W'($urandom_range(7, 6));
    else cmd = chbc_pkg::CMD_W'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 4) k = '0;
    else if (pick < 10) k = $urandom;
    else k = key_set[$urandom_range(47)];
    clock_ms += $urandom_range(300);
    if ($urandom_range(19) == 0) t = $urandom;
    else t = chbc_pkg::TIME_W'(clock_ms);
    send_command(cmd, k, t, $urandom_range(3) == 0 ? 6'($urandom) : 6'($urandom_range(1)),
                 $urandom_range(7) == 0, {$urandom, $urandom});
  endtask

  task automatic test_random_phases();
    for (int i = 0; i < 48; i++)
      key_set[i] = (i < 16) ? 32'(i % 4 + 1 + (i / 4) * NBUCK) : $urandom | 32'd1;
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 8 : (p == 1) ? 51 : 0;
      write_config(chbc_pkg::CFG_FRESH, chbc_pkg::CFG_W'($urandom_range(1000)));
      write_config(chbc_pkg::CFG_EXPIRE, chbc_pkg::CFG_W'($urandom_range(20000)));
      for (int i = 0; i < 200; i++) random_item();
    end
  endtask

  initial begin
    wipe_cache();
    sh_fresh = chbc_pkg::FRESH_RST;
    sh_expire = chbc_pkg::EXPIRE_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_extremes();
    test_pool_full();
    test_random_phases();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: chained_hash_bounds_cache_core.f
sv/chbc_pkg.sv
sv/chbc_ram.sv
sv/chbc_mod.sv
sv/chbc_datapath.sv
sv/chbc_ctrl.sv
sv/chained_hash_bounds_cache_core.sv
test/chained_hash_bounds_cache_core_tb.sv
